// ===== sv/spq_pkg.sv =====
// shared types, codes and constants for the sorted priority queue
package spq_pkg;

	// default number of cells in the row
	localparam int unsigned DEPTH_DEF = 16;

	// request kind codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_LIST   = 2'd2;

	// response status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic signed [31:0]  value;
		logic signed [15:0]  prio;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic signed [31:0]  out_value;
		logic                last;
	} rsp_t;

	// one stored queue entry
	typedef struct packed {
		logic signed [31:0]  value;
		logic signed [15:0]  prio;
	} entry_t;

	// operation broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_SHIFT  = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t  op;
		entry_t    ent;
	} cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
// one cell of the sorted entry row
module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  cell_cmd_t  cmd,
	input  entry_t     left_ent,
	input  logic       left_move,
	input  entry_t     right_ent,
	input  entry_t     head_ent,
	input  logic       occupied,
	input  logic       tail,
	output entry_t     ent,
	output logic       move
);

	entry_t ent_q;
	entry_t ent_nxt;

	// cell yields its place when empty or holding a strictly larger priority
	assign move = !occupied || (ent_q.prio > cmd.ent.prio);
	assign ent  = ent_q;

	// next contents
	always_comb begin
		case (cmd.op)
			OP_INSERT: begin
				if (left_move) begin
					ent_nxt = left_ent;
				end else if (move) begin
					ent_nxt = cmd.ent;
				end else begin
					ent_nxt = ent_q;
				end
			end
			OP_SHIFT: begin
				ent_nxt = right_ent;
			end
			OP_ROTATE: begin
				ent_nxt = tail ? head_ent : right_ent;
			end
			default: begin
				ent_nxt = ent_q;
			end
		endcase
	end

	// entry storage
	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// sorted priority queue built as a row of shifting entry cells
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------
//  request | req_valid/req_stall | req  (kind, value, prio)
//  response| rsp_valid/rsp_stall | rsp  (status, out_value, last)
//
// insert and remove act on the whole row at once: every cell compares and shifts in parallel
// list enters a list state, then streams the stored entries in priority order, rotating the row
// the response register holds one transfer; requests stall while it cannot drain
// requests also stall while a list is being streamed out
// reset clears the entry count and the response valid; cell contents are not reset
module sorted_priority_queue_top
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	input  req_t  req,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LIST = 2'b10
	} state_t;

	state_t     state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] list_left_q;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	logic       out_free;
	logic       req_fire;
	logic       res_valid;
	rsp_t       res;
	cell_cmd_t  cmd;
	entry_t     ent_w  [DEPTH];
	logic       move_w [DEPTH];
	logic       is_full;
	logic       is_empty;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q == ST_LIST) || !out_free;
	assign req_fire  = req_valid && !req_stall;
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);

	// decode the request or the list step into a cell command and a result
	always_comb begin
		cmd.op        = OP_HOLD;
		cmd.ent.value = req.value;
		cmd.ent.prio  = req.prio;
		res_valid     = 1'b0;
		res.status    = STATUS_OK;
		res.out_value = '0;
		res.last      = 1'b1;
		if (state_q == ST_LIST) begin
			if (out_free) begin
				cmd.op        = OP_ROTATE;
				res_valid     = 1'b1;
				res.out_value = ent_w[0].value;
				res.last      = (list_left_q == CW'(1));
			end
		end else if (req_fire) begin
			case (req.kind)
				KIND_INSERT: begin
					res_valid = 1'b1;
					if (is_full) begin
						res.status = STATUS_FULL;
					end else begin
						cmd.op = OP_INSERT;
					end
				end
				KIND_REMOVE: begin
					res_valid = 1'b1;
					if (is_empty) begin
						res.status = STATUS_EMPTY;
					end else begin
						cmd.op        = OP_SHIFT;
						res.out_value = ent_w[0].value;
					end
				end
				KIND_LIST: begin
					if (is_empty) begin
						res_valid  = 1'b1;
						res.status = STATUS_EMPTY;
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	// row of cells
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			entry_t left_ent;
			logic   left_move;
			entry_t right_ent;
			if (gi == 0) begin : g_first
				assign left_ent  = cmd.ent;
				assign left_move = 1'b0;
			end else begin : g_mid
				assign left_ent  = ent_w[gi-1];
				assign left_move = move_w[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_ent = ent_w[gi];
			end else begin : g_inner
				assign right_ent = ent_w[gi+1];
			end
			spq_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.left_ent  (left_ent),
				.left_move (left_move),
				.right_ent (right_ent),
				.head_ent  (ent_w[0]),
				.occupied  (count_q > CW'(gi)),
				.tail      (count_q == CW'(gi + 1)),
				.ent       (ent_w[gi]),
				.move      (move_w[gi])
			);
		end
	endgenerate

	// control state: entry count and list sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			list_left_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire && req.kind == KIND_LIST && !is_empty) begin
						state_q     <= ST_LIST;
						list_left_q <= count_q;
					end
					if (cmd.op == OP_INSERT) begin
						count_q <= count_q + CW'(1);
					end else if (cmd.op == OP_SHIFT) begin
						count_q <= count_q - CW'(1);
					end
				end
				ST_LIST: begin
					if (out_free) begin
						list_left_q <= list_left_q - CW'(1);
						if (list_left_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// the entry count never exceeds the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// an accepted insert into a non-full queue grows the count by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.kind == KIND_INSERT && !is_full)
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow count");

	// while listing, the remaining count is nonzero and at most the entry count
	a_list_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIST) |-> (list_left_q != '0 && list_left_q <= count_q))
		else $error("list counter out of range");

	// an empty or full status is always the final transfer of its request
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == STATUS_EMPTY || rsp.status == STATUS_FULL))
		|-> rsp.last)
		else $error("error status without last");
`endif

endmodule

// ===== test/sorted_priority_queue_top_test.sv =====
// self-checking testbench for the sorted priority queue top level
module sorted_priority_queue_top_test;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_CYCLES = 150;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// stimulus entry: request plus a flag to wait for all responses first
	typedef struct {
		req_t r;
		bit   drain_first;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	sorted_priority_queue_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	stim_t req_backlog[$];
	rsp_t  rsp_due_q[$];
	int    rsp_due = 0;
	int    rsp_seen = 0;
	int    errors = 0;
	int    cycles = 0;

	// sorted list kept by the testbench
	logic signed [31:0] list_value [DEPTH];
	logic signed [15:0] list_prio [DEPTH];
	int                 list_len = 0;

	function automatic void add_rsp(logic [1:0] status, logic signed [31:0] val, logic last);
		rsp_t o;
		o.status = status;
		o.out_value = val;
		o.last = last;
		rsp_due_q.push_back(o);
		rsp_due++;
	endfunction

	// update the sorted list for one request and queue its responses
	function automatic void apply_request(req_t r);
		int pos;
		int i;
		logic signed [15:0] p;
		p = r.prio;
		case (r.kind)
			KIND_INSERT: begin
				if (list_len >= DEPTH) begin
					add_rsp(STATUS_FULL, 32'sd0, 1'b1);
				end else begin
					pos = 0;
					while (pos < list_len && list_prio[pos] <= p)
						pos++;
					for (i = list_len; i > pos; i--) begin
						list_value[i] = list_value[i - 1];
						list_prio[i] = list_prio[i - 1];
					end
					list_value[pos] = r.value;
					list_prio[pos] = p;
					list_len++;
					add_rsp(STATUS_OK, 32'sd0, 1'b1);
				end
			end
			KIND_REMOVE: begin
				if (list_len == 0) begin
					add_rsp(STATUS_EMPTY, 32'sd0, 1'b1);
				end else begin
					add_rsp(STATUS_OK, list_value[0], 1'b1);
					for (i = 1; i < list_len; i++) begin
						list_value[i - 1] = list_value[i];
						list_prio[i - 1] = list_prio[i];
					end
					list_len--;
				end
			end
			KIND_LIST: begin
				if (list_len == 0) begin
					add_rsp(STATUS_EMPTY, 32'sd0, 1'b1);
				end else begin
					for (i = 0; i < list_len; i++)
						add_rsp(STATUS_OK, list_value[i], (i + 1 == list_len));
				end
			end
			default: begin
				// unused kind: ignored, no response
			end
		endcase
	endfunction

	task automatic add_req(logic [1:0] kind, logic signed [31:0] value,
			logic signed [15:0] prio, bit drain_first);
		stim_t s;
		s.r.kind = kind;
		s.r.value = value;
		s.r.prio = prio;
		s.drain_first = drain_first;
		req_backlog.push_back(s);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// mostly a narrow range so that equal priorities are common
	function automatic logic signed [15:0] pick_prio();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return 16'($urandom);
			default: return 16'($urandom_range(0, 6) - 3);
		endcase
	endfunction

	int burst_left = 1;
	int gap_left = 0;

	// driver: present backlog items in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin : drv
		logic offer;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			offer = req_valid;
			if (req_valid && !req_stall) begin
				apply_request(req);
				void'(req_backlog.pop_front());
				offer = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_backlog.size() != 0 &&
						!(req_backlog[0].drain_first && rsp_due != rsp_seen)) begin
					offer = 1'b1;
					req <= req_backlog[0].r;
				end
			end
			req_valid <= offer;
		end
	end

	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	// receiver: stall pattern changing over time, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			stall_phase++;
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (!hold_done && rsp_seen >= 40) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= (stall_phase % 3 == 0);
				endcase
			end
		end
	end

	task automatic report_mismatch(string what, rsp_t exp, rsp_t got);
		errors++;
		if (errors <= 10)
			$display("%s: expected status %0d value %0d last %0d, got status %0d value %0d last %0d",
				what, exp.status, exp.out_value, exp.last, got.status, got.out_value, got.last);
	endtask

	// monitor: compare each response transfer with the oldest expected one
	always @(posedge clk) begin : mon
		rsp_t exp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_seen <= rsp_seen + 1;
			if (rsp_due_q.size() == 0) begin
				report_mismatch("unexpected response", '0, rsp);
			end else begin
				exp = rsp_due_q.pop_front();
				if (rsp.status !== exp.status || rsp.out_value !== exp.out_value ||
						rsp.last !== exp.last)
					report_mismatch("response mismatch", exp, rsp);
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int made;
		int seg_len;
		int style;
		int roll;
		int i;
		bit first_seg;
		logic [1:0] kind;

		// directed: empty cases, extremes, equal priorities, drain to empty
		add_req(KIND_LIST, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_REMOVE, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_UNUSED, 32'sh5a5a5a5a, 16'sh1234, 1'b0);
		add_req(KIND_INSERT, 32'sh7fffffff, 16'sh7fff, 1'b0);
		add_req(KIND_INSERT, 32'sh80000000, 16'sh8000, 1'b0);
		add_req(KIND_INSERT, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_INSERT, -32'sd1, 16'sd0, 1'b0);
		add_req(KIND_INSERT, 32'sd12345, 16'sd0, 1'b0);
		add_req(KIND_INSERT, -32'sd5, -16'sd1, 1'b0);
		add_req(KIND_LIST, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_REMOVE, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_REMOVE, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_LIST, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_INSERT, 32'sd777, 16'sh7fff, 1'b0);
		add_req(KIND_LIST, 32'sd0, 16'sd0, 1'b0);
		for (i = 0; i < 5; i++)
			add_req(KIND_REMOVE, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_REMOVE, 32'sd0, 16'sd0, 1'b0);
		add_req(KIND_LIST, 32'sd0, 16'sd0, 1'b0);

		// random segments with different operation mixes
		made = 0;
		first_seg = 1'b1;
		while (made < RANDOM_ITEMS) begin
			style = first_seg ? 0 : $urandom_range(0, 4);
			seg_len = (style == 0) ? DEPTH + 3 : $urandom_range(10, 25);
			for (i = 0; i < seg_len; i++) begin
				roll = $urandom_range(0, 99);
				case (style)
					0: kind = KIND_INSERT;
					1: kind = (roll < 80) ? KIND_INSERT : (roll < 90) ? KIND_REMOVE : KIND_LIST;
					2: kind = (roll < 20) ? KIND_INSERT : (roll < 85) ? KIND_REMOVE : KIND_LIST;
					3: kind = (roll < 45) ? KIND_INSERT : (roll < 80) ? KIND_REMOVE : KIND_LIST;
					default: kind = (roll < 40) ? KIND_INSERT : (roll < 60) ? KIND_REMOVE : KIND_LIST;
				endcase
				// occasional noise with the unused code
				if ($urandom_range(0, 99) < 3)
					add_req(KIND_UNUSED, $urandom, 16'($urandom), 1'b0);
				add_req(kind, pick_value(), pick_prio(), (i == 0));
				made++;
			end
			if (style == 0)
				add_req(KIND_LIST, pick_value(), pick_prio(), 1'b0);
			first_seg = 1'b0;
		end

		// reset
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all stimulus and responses, then a tail
		while (req_backlog.size() != 0 || rsp_due_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		if (errors == 0 && rsp_due_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
